[rtl/lbs_pkg.sv]
// ----------------------------------------------------------------------------
// lbs_pkg
// Types and constants shared by the LED task blink sequencer.
// ----------------------------------------------------------------------------
package lbs_pkg;

	// item kinds
	localparam logic [1:0] KIND_TICK   = 2'd0;
	localparam logic [1:0] KIND_TASK   = 2'd1;
	localparam logic [1:0] KIND_DIRECT = 2'd2;

	// task codes
	localparam logic [2:0] TASK_NONE    = 3'd0;
	localparam logic [2:0] TASK_ON      = 3'd1;
	localparam logic [2:0] TASK_OFF     = 3'd2;
	localparam logic [2:0] TASK_TOGGLE  = 3'd3;
	localparam logic [2:0] TASK_BLINK1  = 3'd4;
	localparam logic [2:0] TASK_BLINK2  = 3'd5;
	localparam logic [2:0] TASK_BLINK3  = 3'd6;
	localparam logic [2:0] TASK_INVALID = 3'd7;

	// blink repeat counts
	localparam logic [2:0] TIMES_ONE   = 3'd1;
	localparam logic [2:0] TIMES_TWO   = 3'd2;
	localparam logic [2:0] TIMES_THREE = 3'd3;

	// register indexes
	localparam logic [1:0] CFG_ON_TIME   = 2'd0;
	localparam logic [1:0] CFG_OFF_TIME  = 2'd1;
	localparam logic [1:0] CFG_INTENSITY = 2'd2;

	// register reset values
	localparam logic [15:0] ON_TIME_RST   = 16'd20;
	localparam logic [15:0] OFF_TIME_RST  = 16'd250;
	localparam logic [7:0]  INTENSITY_RST = 8'd255;

	// direct command bytes
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_ONE   = 8'h31;
	localparam logic [7:0] DIRECT_LEN = 8'd1;

	typedef enum logic [2:0] {
		PH_START,
		PH_CHECK,
		PH_B1,
		PH_B2,
		PH_B3
	} ctrl_phase_t;

	typedef enum logic [1:0] {
		BL_START,
		BL_CHECK,
		BL_ON,
		BL_OFF
	} blink_phase_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [2:0] task_req;
		logic [7:0] payload_byte;
		logic [7:0] payload_length;
	} item_t;

	typedef struct packed {
		logic       led_on;
		logic [7:0] pwm_level;
		logic [2:0] current_task;
		logic       blinking;
	} result_t;

	typedef struct packed {
		logic [15:0] on_time_ms;
		logic [15:0] off_time_ms;
		logic [7:0]  intensity;
	} cfg_t;

	typedef struct packed {
		ctrl_phase_t  ctrl;
		blink_phase_t blink;
		logic [2:0]   count;
		logic [15:0]  time_left;
		logic [2:0]   pending;
		logic         led;
	} state_t;

endpackage

[rtl/lbs_ifs.sv]
// ----------------------------------------------------------------------------
// lbs_ifs
// Channel interfaces: input items, result items and register writes.
// ----------------------------------------------------------------------------
interface lbs_item_if;
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	logic [2:0] task_req;
	logic [7:0] payload_byte;
	logic [7:0] payload_length;

	modport source (output valid, kind, task_req, payload_byte, payload_length, input ready);
	modport sink (input valid, kind, task_req, payload_byte, payload_length, output ready);
endinterface

interface lbs_result_if;
	logic       valid;
	logic       ready;
	logic       led_on;
	logic [7:0] pwm_level;
	logic [2:0] current_task;
	logic       blinking;

	modport source (output valid, led_on, pwm_level, current_task, blinking, input ready);
	modport sink (input valid, led_on, pwm_level, current_task, blinking, output ready);
endinterface

interface lbs_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [15:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

[rtl/lbs_step.sv]
// ----------------------------------------------------------------------------
// lbs_step
// Next-state and result logic for one request of the sequencer.
// ----------------------------------------------------------------------------
module lbs_step
	import lbs_pkg::*;
(
	input  state_t  st,
	input  item_t   itm,
	input  cfg_t    cfg,
	output state_t  nxt,
	output result_t res
);

	logic [2:0] taken;

	// next state
	always_comb begin
		logic [2:0]  times;
		logic [2:0]  cnt;
		logic [15:0] dec;
		nxt   = st;
		taken = TASK_NONE;
		times = TIMES_ONE;
		cnt   = st.count + 3'd1;
		dec   = (st.time_left != 16'd0) ? st.time_left - 16'd1 : 16'd0;
		unique case (st.ctrl)
			PH_B2:   times = TIMES_TWO;
			PH_B3:   times = TIMES_THREE;
			default: times = TIMES_ONE;
		endcase
		if (st.blink == BL_START) begin
			cnt = 3'd1;
		end
		unique case (itm.kind)
			KIND_TICK: begin
				unique case (st.ctrl)
					PH_START: nxt.ctrl = PH_CHECK;
					PH_CHECK: begin
						taken       = st.pending;
						nxt.pending = TASK_NONE;
						unique case (st.pending)
							TASK_ON:     nxt.led = 1'b1;
							TASK_OFF:    nxt.led = 1'b0;
							TASK_TOGGLE: nxt.led = ~st.led;
							TASK_BLINK1: nxt.ctrl = PH_B1;
							TASK_BLINK2: nxt.ctrl = PH_B2;
							TASK_BLINK3: nxt.ctrl = PH_B3;
							default:     nxt.ctrl = PH_CHECK;
						endcase
					end
					default: begin
						// blink pass
						unique case (st.blink)
							BL_START, BL_CHECK: begin
								nxt.count = cnt;
								if (cnt > times) begin
									nxt.blink = BL_START;
									nxt.ctrl  = PH_CHECK;
								end else begin
									nxt.led       = 1'b1;
									nxt.time_left = cfg.on_time_ms;
									nxt.blink     = BL_ON;
								end
							end
							BL_ON: begin
								nxt.time_left = dec;
								if (dec == 16'd0) begin
									nxt.led       = 1'b0;
									nxt.time_left = cfg.off_time_ms;
									nxt.blink     = BL_OFF;
								end
							end
							default: begin
								nxt.time_left = dec;
								if (dec == 16'd0) begin
									nxt.blink = BL_CHECK;
								end
							end
						endcase
					end
				endcase
			end
			KIND_TASK: begin
				if (itm.task_req != TASK_INVALID) begin
					nxt.pending = itm.task_req;
				end
			end
			KIND_DIRECT: begin
				if (itm.payload_length == DIRECT_LEN) begin
					if (itm.payload_byte == CHAR_ZERO) begin
						nxt.led = 1'b0;
					end else if (itm.payload_byte == CHAR_ONE) begin
						nxt.led = 1'b1;
					end
				end
			end
			default: nxt = st;
		endcase
	end

	// result
	always_comb begin
		res.led_on       = nxt.led;
		res.pwm_level    = nxt.led ? cfg.intensity : 8'd0;
		res.current_task = taken;
		res.blinking     = (nxt.ctrl == PH_B1) || (nxt.ctrl == PH_B2) || (nxt.ctrl == PH_B3);
	end

endmodule

[rtl/led_task_blink_sequencer.sv]
// ----------------------------------------------------------------------------
// led_task_blink_sequencer
// LED task sequencer: ticks, task requests and direct commands drive the LED.
// ----------------------------------------------------------------------------
//  channel | dir | handshake     | payload
//  item    | in  | valid / ready | kind, task_req, payload_byte, payload_length
//  result  | out | valid / ready | led_on, pwm_level, current_task, blinking
//  cfg     | in  | valid / ready | index, data (always ready)
//
//  One request per cycle sustained while the result side is ready; a request
//  passes through the input register, then the result register.
//  The state update runs in one pass between the input and result registers.
//  Reset clears the sequencer state and loads the register defaults.
//  A stalled result holds the input register; item.ready drops only when
//  both the input register and the result register are full and stalled.
// ----------------------------------------------------------------------------
module led_task_blink_sequencer
	import lbs_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	lbs_item_if.sink      item,
	lbs_result_if.source  result,
	lbs_cfg_if.sink       cfg
);

	cfg_t    cfg_q;
	state_t  state_q;
	state_t  state_nxt;
	item_t   item_s1;
	logic    valid_s1;
	result_t res_nxt;
	result_t res_s2;
	logic    valid_s2;
	logic    advance;

	// handshakes
	assign advance    = valid_s1 && (!valid_s2 || result.ready);
	assign item.ready = !valid_s1 || advance;
	assign cfg.ready  = 1'b1;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.on_time_ms  <= ON_TIME_RST;
			cfg_q.off_time_ms <= OFF_TIME_RST;
			cfg_q.intensity   <= INTENSITY_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_ON_TIME:   cfg_q.on_time_ms  <= cfg.data;
				CFG_OFF_TIME:  cfg_q.off_time_ms <= cfg.data;
				CFG_INTENSITY: cfg_q.intensity   <= cfg.data[7:0];
				default:       cfg_q             <= cfg_q;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.valid && item.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			item_s1.kind           <= item.kind;
			item_s1.task_req       <= item.task_req;
			item_s1.payload_byte   <= item.payload_byte;
			item_s1.payload_length <= item.payload_length;
		end
	end

	lbs_step u_step (
		.st  (state_q),
		.itm (item_s1),
		.cfg (cfg_q),
		.nxt (state_nxt),
		.res (res_nxt)
	);

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.ctrl      <= PH_START;
			state_q.blink     <= BL_START;
			state_q.count     <= 3'd0;
			state_q.time_left <= 16'd0;
			state_q.pending   <= TASK_NONE;
			state_q.led       <= 1'b0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (result.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_nxt;
		end
	end

	assign result.valid        = valid_s2;
	assign result.led_on       = res_s2.led_on;
	assign result.pwm_level    = res_s2.pwm_level;
	assign result.current_task = res_s2.current_task;
	assign result.blinking     = res_s2.blinking;

endmodule

[rtl/lbs_chk.sv]
// ----------------------------------------------------------------------------
// lbs_chk
// Port-level assertions for the LED task sequencer, bound to the top level.
// ----------------------------------------------------------------------------
module lbs_chk
	import lbs_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       res_valid,
	input logic       res_ready,
	input logic       led_on,
	input logic [7:0] pwm_level,
	input logic [2:0] current_task,
	input logic       blinking
);

	// a stalled result keeps its payload
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(led_on) && $stable(pwm_level)
			&& $stable(current_task) && $stable(blinking))
		else $error("result changed while stalled");

	// pwm is only driven while the led is on
	a_pwm_off: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !led_on |-> pwm_level == 8'd0)
		else $error("pwm level nonzero with led off");

	// on and off tasks take effect in the same pass
	a_task_led: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (current_task == TASK_ON || current_task == TASK_OFF)
			|-> led_on == (current_task == TASK_ON))
		else $error("on/off task did not set the led");

	// a blink task starts a blink sequence
	a_task_blink: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (current_task == TASK_BLINK1 || current_task == TASK_BLINK2
			|| current_task == TASK_BLINK3) |-> blinking)
		else $error("blink task taken without blinking");

	// a taken task never reports the invalid code
	a_task_code: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> current_task != TASK_INVALID)
		else $error("invalid task code reported");

endmodule

bind led_task_blink_sequencer lbs_chk u_lbs_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.res_valid    (result.valid),
	.res_ready    (result.ready),
	.led_on       (result.led_on),
	.pwm_level    (result.pwm_level),
	.current_task (result.current_task),
	.blinking     (result.blinking)
);

[verif/led_sequence_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_sequence_checker
// Watches the request, result and register channels of the LED task blink
// sequencer, keeps its own copy of the sequencer state and registers, works
// out the result each accepted request should give and compares results in
// order against those predictions.
// ----------------------------------------------------------------------------
module led_sequence_checker
	import lbs_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	lbs_item_if   item,
	lbs_result_if result,
	lbs_cfg_if    cfg,
	output int    mismatches,
	output int    results_due,
	output int    results_checked,
	output int    blinks_taken
);

	state_t  seq;
	cfg_t    regs;
	result_t predicted_results[$];
	int      fails;
	int      checked;
	int      blinks;

	// one request applied to the shadow state, giving the result it should cause
	function automatic result_t advance_led_state(input item_t req);
		logic [2:0] taken;
		logic [2:0] times;
		result_t    r;
		taken = TASK_NONE;
		case (req.kind)
			KIND_TICK: begin
				case (seq.ctrl)
					PH_START: seq.ctrl = PH_CHECK;
					PH_CHECK: begin
						taken = seq.pending;
						case (seq.pending)
							TASK_ON:     seq.led = 1'b1;
							TASK_OFF:    seq.led = 1'b0;
							TASK_TOGGLE: seq.led = ~seq.led;
							TASK_BLINK1: seq.ctrl = PH_B1;
							TASK_BLINK2: seq.ctrl = PH_B2;
							TASK_BLINK3: seq.ctrl = PH_B3;
							default: ;
						endcase
						seq.pending = TASK_NONE;
					end
					PH_B1, PH_B2, PH_B3: begin
						if (seq.ctrl == PH_B1)
							times = TIMES_ONE;
						else if (seq.ctrl == PH_B2)
							times = TIMES_TWO;
						else
							times = TIMES_THREE;
						case (seq.blink)
							BL_START, BL_CHECK: begin
								if (seq.blink == BL_START)
									seq.count = 3'd0;
								seq.count = seq.count + 3'd1;
								if (seq.count > times) begin
									// all repeats done, back to task checking
									seq.blink = BL_START;
									seq.ctrl  = PH_CHECK;
								end else begin
									seq.led       = 1'b1;
									seq.time_left = regs.on_time_ms;
									seq.blink     = BL_ON;
								end
							end
							BL_ON: begin
								if (seq.time_left != 16'd0)
									seq.time_left = seq.time_left - 16'd1;
								if (seq.time_left == 16'd0) begin
									seq.led       = 1'b0;
									seq.time_left = regs.off_time_ms;
									seq.blink     = BL_OFF;
								end
							end
							default: begin
								if (seq.time_left != 16'd0)
									seq.time_left = seq.time_left - 16'd1;
								if (seq.time_left == 16'd0)
									seq.blink = BL_CHECK;
							end
						endcase
					end
					default: ;
				endcase
			end
			KIND_TASK: begin
				if (req.task_req != TASK_INVALID)
					seq.pending = req.task_req;
			end
			KIND_DIRECT: begin
				if (req.payload_length == DIRECT_LEN) begin
					if (req.payload_byte == CHAR_ZERO)
						seq.led = 1'b0;
					else if (req.payload_byte == CHAR_ONE)
						seq.led = 1'b1;
				end
			end
			default: ;
		endcase
		r.led_on       = seq.led;
		r.pwm_level    = seq.led ? regs.intensity : 8'd0;
		r.current_task = taken;
		r.blinking     = (seq.ctrl == PH_B1) || (seq.ctrl == PH_B2) || (seq.ctrl == PH_B3);
		return r;
	endfunction

	// register shadow, prediction on each request, in-order compare on each result
	always @(posedge clk or negedge arst_n) begin
		item_t   req;
		result_t want;
		result_t got;
		if (!arst_n) begin
			seq.ctrl          = PH_START;
			seq.blink         = BL_START;
			seq.count         = 3'd0;
			seq.time_left     = 16'd0;
			seq.pending       = TASK_NONE;
			seq.led           = 1'b0;
			regs.on_time_ms   = ON_TIME_RST;
			regs.off_time_ms  = OFF_TIME_RST;
			regs.intensity    = INTENSITY_RST;
			predicted_results.delete();
			fails           = 0;
			checked         = 0;
			blinks          = 0;
			mismatches      <= 0;
			results_due     <= 0;
			results_checked <= 0;
			blinks_taken    <= 0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					CFG_ON_TIME:   regs.on_time_ms  = cfg.data;
					CFG_OFF_TIME:  regs.off_time_ms = cfg.data;
					CFG_INTENSITY: regs.intensity   = cfg.data[7:0];
					default: ;
				endcase
			end

			// results first, so a same-edge request never lines up with its own result
			if (result.valid && result.ready) begin
				got.led_on       = result.led_on;
				got.pwm_level    = result.pwm_level;
				got.current_task = result.current_task;
				got.blinking     = result.blinking;
				if (predicted_results.size() == 0) begin
					if (fails < 10)
						$display("%0t: result with none due: led_on=%0b pwm=%0d task=%0d blink=%0b",
							$realtime, got.led_on, got.pwm_level, got.current_task, got.blinking);
					fails++;
				end else begin
					want = predicted_results.pop_front();
					checked++;
					if (got.led_on !== want.led_on || got.pwm_level !== want.pwm_level ||
						got.current_task !== want.current_task ||
						got.blinking !== want.blinking) begin
						if (fails < 10) begin
							$display("%0t: result %0d wrong", $realtime, checked);
							$display("  expected led_on=%0b pwm=%0d task=%0d blink=%0b",
								want.led_on, want.pwm_level, want.current_task, want.blinking);
							$display("  actual   led_on=%0b pwm=%0d task=%0d blink=%0b",
								got.led_on, got.pwm_level, got.current_task, got.blinking);
						end
						fails++;
					end
				end
			end

			if (item.valid && item.ready) begin
				req.kind           = item.kind;
				req.task_req       = item.task_req;
				req.payload_byte   = item.payload_byte;
				req.payload_length = item.payload_length;
				want = advance_led_state(req);
				if (want.current_task >= TASK_BLINK1 && want.current_task <= TASK_BLINK3)
					blinks++;
				predicted_results.push_back(want);
			end

			mismatches      <= fails;
			results_due     <= predicted_results.size();
			results_checked <= checked;
			blinks_taken    <= blinks;
		end
	end

endmodule

[verif/led_task_blink_sequencer_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_task_blink_sequencer_tb
// Drives ticks, task requests and direct commands into the LED task blink
// sequencer under several register settings, with bursty requests and a
// stalling result side; the checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module led_task_blink_sequencer_tb;
	import lbs_pkg::*;

	localparam logic [1:0] KIND_SPARE   = 2'd3;
	localparam logic [1:0] CFG_UNUSED   = 2'd3;
	localparam int         PHASES       = 12;
	localparam int         PHASE_ITEMS  = 160;
	localparam int         IDLE_LIMIT   = 2000;

	logic clk;
	logic arst_n;

	lbs_item_if   item_ch ();
	lbs_result_if result_ch ();
	lbs_cfg_if    cfg_ch ();

	int mismatches;
	int results_due;
	int results_checked;
	int blinks_taken;

	int          burst_left;
	int          requests_sent;
	int          settings_used;
	int          idle_cycles;
	int unsigned stall_step;
	int unsigned stall_mode;

	led_task_blink_sequencer dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	led_sequence_checker checker_i (
		.clk             (clk),
		.arst_n          (arst_n),
		.item            (item_ch),
		.result          (result_ch),
		.cfg             (cfg_ch),
		.mismatches      (mismatches),
		.results_due     (results_due),
		.results_checked (results_checked),
		.blinks_taken    (blinks_taken)
	);

	// 10 ns clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic item_t make_request(input logic [1:0] k, input logic [2:0] t,
		input logic [7:0] b, input logic [7:0] l);
		item_t r;
		r.kind           = k;
		r.task_req       = t;
		r.payload_byte   = b;
		r.payload_length = l;
		return r;
	endfunction

	// mostly ticks and valid tasks so blinks run to the end, plus noise
	function automatic item_t random_request();
		item_t       r;
		int unsigned pick;
		pick             = $urandom_range(0, 99);
		r.task_req       = 3'($urandom_range(0, 7));
		r.payload_byte   = 8'($urandom_range(0, 255));
		r.payload_length = 8'($urandom_range(0, 255));
		if (pick < 62) begin
			r.kind = KIND_TICK;
		end else if (pick < 80) begin
			r.kind = KIND_TASK;
			if ($urandom_range(0, 9) != 0)
				r.task_req = 3'($urandom_range(TASK_ON, TASK_BLINK3));
		end else if (pick < 96) begin
			r.kind = KIND_DIRECT;
			if ($urandom_range(0, 3) != 0) begin
				r.payload_length = DIRECT_LEN;
				r.payload_byte   = $urandom_range(0, 1) ? CHAR_ONE : CHAR_ZERO;
			end else if ($urandom_range(0, 1) != 0) begin
				r.payload_length = DIRECT_LEN;
			end
		end else begin
			r.kind = KIND_SPARE;
		end
		return r;
	endfunction

	// one request, with bursts and random gaps between them
	task automatic send_request(input item_t r);
		int unsigned gap;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 24);
			gap = $urandom_range(0, 6);
			if (gap != 0) begin
				item_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		item_ch.valid          <= 1'b1;
		item_ch.kind           <= r.kind;
		item_ch.task_req       <= r.task_req;
		item_ch.payload_byte   <= r.payload_byte;
		item_ch.payload_length <= r.payload_length;
		do
			@(posedge clk);
		while (!item_ch.ready);
		requests_sent++;
	endtask

	// hold off until every predicted result has come back
	task automatic wait_drained();
		item_ch.valid <= 1'b0;
		do
			@(posedge clk);
		while (results_due != 0);
	endtask

	// valid stays high for back-to-back writes; the caller drops it after the last
	task automatic write_register(input logic [1:0] index, input logic [15:0] data);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= index;
		cfg_ch.data  <= data;
		do
			@(posedge clk);
		while (!cfg_ch.ready);
	endtask

	// result side stalls in a few modes of its own
	initial begin
		result_ch.ready = 1'b0;
		stall_step      = 0;
		stall_mode      = 0;
		forever begin
			@(posedge clk);
			stall_step++;
			if (stall_step[5:0] == 6'd0)
				stall_mode = $urandom_range(0, 3);
			case (stall_mode)
				0:       result_ch.ready <= 1'b1;
				1:       result_ch.ready <= 1'($urandom_range(0, 1));
				2:       result_ch.ready <= ($urandom_range(0, 3) == 0);
				default: result_ch.ready <= (stall_step[2:0] != 3'd5) && (stall_step[3:1] != 3'd2);
			endcase
		end
	end

	// watchdog: too long with no handshake on any channel
	initial begin
		idle_cycles = 0;
		forever begin
			@(posedge clk);
			if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready) ||
				(cfg_ch.valid && cfg_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("timeout: no handshake for %0d cycles, %0d results still due",
					idle_cycles, results_due);
				$display("Mismatches found");
				$finish;
			end
		end
	end

	// stimulus
	initial begin
		arst_n                 = 1'b0;
		item_ch.valid          = 1'b0;
		item_ch.kind           = KIND_TICK;
		item_ch.task_req       = TASK_NONE;
		item_ch.payload_byte   = 8'd0;
		item_ch.payload_length = 8'd0;
		cfg_ch.valid           = 1'b0;
		cfg_ch.index           = CFG_ON_TIME;
		cfg_ch.data            = 16'd0;
		burst_left             = 0;
		requests_sent          = 0;
		settings_used          = 1;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: basic tasks and direct commands under reset registers
		send_request(make_request(KIND_TICK, TASK_NONE, 8'h00, 8'h00));
		send_request(make_request(KIND_TASK, TASK_ON, 8'hFF, 8'hFF));
		send_request(make_request(KIND_TICK, TASK_INVALID, 8'h00, 8'h00));
		send_request(make_request(KIND_TASK, TASK_TOGGLE, 8'h00, 8'h00));
		send_request(make_request(KIND_TICK, TASK_NONE, 8'h00, 8'h00));
		send_request(make_request(KIND_DIRECT, TASK_NONE, CHAR_ONE, DIRECT_LEN));
		send_request(make_request(KIND_DIRECT, TASK_NONE, CHAR_ZERO, DIRECT_LEN));
		send_request(make_request(KIND_DIRECT, TASK_NONE, CHAR_ONE, 8'd0));
		send_request(make_request(KIND_DIRECT, TASK_INVALID, 8'h32, DIRECT_LEN));
		send_request(make_request(KIND_DIRECT, TASK_NONE, CHAR_ONE, 8'd255));
		send_request(make_request(KIND_SPARE, TASK_INVALID, 8'hFF, 8'hFF));
		// invalid request leaves the pending one, none clears it
		send_request(make_request(KIND_TASK, TASK_OFF, 8'h00, 8'h00));
		send_request(make_request(KIND_TASK, TASK_INVALID, 8'h00, 8'h00));
		send_request(make_request(KIND_TASK, TASK_NONE, 8'h00, 8'h00));
		send_request(make_request(KIND_TICK, TASK_NONE, 8'h00, 8'h00));
		wait_drained();

		// zero times and zero intensity: a later request overwrites, tasks wait out a blink
		write_register(CFG_ON_TIME, 16'd0);
		write_register(CFG_OFF_TIME, 16'd0);
		write_register(CFG_INTENSITY, 16'h0000);
		cfg_ch.valid <= 1'b0;
		settings_used++;
		send_request(make_request(KIND_TASK, TASK_BLINK2, 8'h00, 8'h00));
		send_request(make_request(KIND_TASK, TASK_BLINK3, 8'h00, 8'h00));
		send_request(make_request(KIND_TICK, TASK_NONE, 8'h00, 8'h00));
		send_request(make_request(KIND_TASK, TASK_ON, 8'h00, 8'h00));
		send_request(make_request(KIND_DIRECT, TASK_NONE, CHAR_ZERO, DIRECT_LEN));
		repeat (11) send_request(make_request(KIND_TICK, TASK_NONE, 8'h00, 8'h00));

		// random phases, small times mostly, the largest values last
		for (int p = 0; p < PHASES; p++) begin
			wait_drained();
			if (p == PHASES - 1) begin
				write_register(CFG_ON_TIME, 16'hFFFF);
				write_register(CFG_OFF_TIME, 16'hFFFF);
				write_register(CFG_INTENSITY, 16'hFFFF);
			end else begin
				write_register(CFG_ON_TIME, 16'($urandom_range(0, (p % 4 == 3) ? 40 : 6)));
				write_register(CFG_OFF_TIME, 16'($urandom_range(0, (p % 4 == 1) ? 40 : 6)));
				write_register(CFG_INTENSITY, 16'($urandom_range(0, 16'hFFFF)));
			end
			write_register(CFG_UNUSED, 16'($urandom_range(0, 16'hFFFF)));
			cfg_ch.valid <= 1'b0;
			settings_used++;
			for (int n = 0; n < PHASE_ITEMS; n++)
				send_request(random_request());
		end

		wait_drained();
		repeat (10) @(posedge clk);
		$display("covered %0d requests over %0d register settings", requests_sent,
			settings_used);
		$display("%0d results compared, %0d blink tasks taken", results_checked, blinks_taken);
		if (mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
